FILE: rtl/ihq_pkg.sv
`default_nettype none
package ihq_pkg;

  localparam int CAPACITY = 256;
  localparam int ID_COUNT = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 32;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_INSERT   = 2'd0;
  localparam kind_t KIND_EXTRACT  = 2'd1;
  localparam kind_t KIND_DECREASE = 2'd2;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_EMPTY      = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_ID_CLASH   = 3'd3,
    STAT_NOT_LOWER  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DEC_SLOT,
    S_DEC_CMP,
    S_UP_TEST,
    S_UP_CMP,
    S_EXT_TAKE,
    S_DOWN_TEST,
    S_DOWN_CMP,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    logic load;
    logic check;
    logic dec_slot;
    logic dec_cmp;
    logic up_test;
    logic up_move;
    logic ext_take;
    logic down_test;
    logic down_move;
    logic place;
    logic finish;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  err;
    logic  not_lower;
    logic  at_root;
    logic  up_stop;
    logic  count_zero;
    logic  down_end;
    logic  down_stop;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/ihq_ctrl.sv
`default_nettype none
module ihq_ctrl
  import ihq_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (sts.err) state_next = S_DONE;
        else if (sts.kind == KIND_INSERT) state_next = S_UP_TEST;
        else if (sts.kind == KIND_EXTRACT) state_next = S_EXT_TAKE;
        else state_next = S_DEC_SLOT;
      end
      S_DEC_SLOT:  state_next = S_DEC_CMP;
      S_DEC_CMP:   state_next = sts.not_lower ? S_DONE : S_UP_TEST;
      S_UP_TEST:   state_next = sts.at_root ? S_PLACE : S_UP_CMP;
      S_UP_CMP:    state_next = sts.up_stop ? S_PLACE : S_UP_TEST;
      S_EXT_TAKE:  state_next = sts.count_zero ? S_DONE : S_DOWN_TEST;
      S_DOWN_TEST: state_next = sts.down_end ? S_PLACE : S_DOWN_CMP;
      S_DOWN_CMP:  state_next = sts.down_stop ? S_PLACE : S_DOWN_TEST;
      S_PLACE:     state_next = S_DONE;
      S_DONE:      if (sts.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK:     cmd.check = 1'b1;
      S_DEC_SLOT:  cmd.dec_slot = 1'b1;
      S_DEC_CMP:   cmd.dec_cmp = 1'b1;
      S_UP_TEST:   cmd.up_test = 1'b1;
      S_UP_CMP:    cmd.up_move = !sts.up_stop;
      S_EXT_TAKE:  cmd.ext_take = 1'b1;
      S_DOWN_TEST: cmd.down_test = 1'b1;
      S_DOWN_CMP:  cmd.down_move = !sts.down_stop;
      S_PLACE:     cmd.place = 1'b1;
      S_DONE:      cmd.finish = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ihq_datapath.sv
`default_nettype none
module ihq_datapath
  import ihq_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  wire  kind_t              in_kind,
  input  wire  [ID_W-1:0]          in_id,
  input  wire  [PRIO_W-1:0]        in_pri,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [ID_W-1:0]          out_id,
  output logic [PRIO_W-1:0]        out_pri,
  output status_t                  out_status,
  output logic [COUNT_W-1:0]       out_count
);

  entry_t              heap_mem [CAPACITY];
  logic [SLOT_W-1:0]   slot_mem [ID_COUNT];
  logic [ID_COUNT-1:0] present;

  kind_t                    kind_r;
  logic [ID_W-1:0]          id_r;
  logic signed [PRIO_W-1:0] key_r;
  logic [SLOT_W-1:0]        s_r;
  logic [COUNT_W-1:0]       c_r;
  logic [COUNT_W-1:0]       count;
  logic [ID_W-1:0]          rid;
  logic [PRIO_W-1:0]        rpri;
  status_t                  stat;

  entry_t            rd_a, rd_b;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] addr_a, addr_b;
  logic              heap_we, slot_we;
  logic [SLOT_W-1:0] heap_waddr, slot_wdata;
  logic [ID_W-1:0]   slot_waddr;
  entry_t            heap_wdata;

  status_t           chk;
  logic [SLOT_W-1:0] par;
  logic              pick_right;
  entry_t            child;
  logic [SLOT_W-1:0] cidx;
  logic [COUNT_W:0]  c_plus;

  always_comb begin
    chk = STAT_OK;
    case (kind_r)
      KIND_INSERT:
        if (present[id_r]) chk = STAT_ID_CLASH;
        else if (count == COUNT_W'(CAPACITY)) chk = STAT_FULL;
      KIND_EXTRACT:
        if (count == '0) chk = STAT_EMPTY;
      KIND_DECREASE:
        if (!present[id_r]) chk = STAT_ID_CLASH;
      default: chk = STAT_OK;
    endcase
  end

  assign par        = SLOT_W'((s_r - 1'b1) >> 1);
  assign c_plus     = {1'b0, c_r} + 1'b1;
  assign pick_right = (c_plus < {1'b0, count}) && (rd_b.pri < rd_a.pri);
  assign child      = pick_right ? rd_b : rd_a;
  assign cidx       = c_r[SLOT_W-1:0] + SLOT_W'(pick_right);

  always_comb begin
    sts            = '0;
    sts.kind       = kind_r;
    sts.err        = (chk != STAT_OK) || (kind_r != KIND_INSERT &&
                     kind_r != KIND_EXTRACT && kind_r != KIND_DECREASE);
    sts.not_lower  = key_r >= rd_a.pri;
    sts.at_root    = (s_r == '0);
    sts.up_stop    = key_r > rd_a.pri;
    sts.count_zero = (count == '0);
    sts.down_end   = (c_r >= count);
    sts.down_stop  = key_r < child.pri;
    sts.out_free   = !out_valid || out_ready;
  end

  // read address selection for the two heap ports
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    if (cmd.check) begin
      addr_b = SLOT_W'(count - 1'b1);
    end else if (cmd.dec_slot) begin
      addr_a = rd_slot;
    end else if (cmd.up_test) begin
      addr_a = par;
    end else if (cmd.down_test) begin
      addr_a = c_r[SLOT_W-1:0];
      addr_b = c_r[SLOT_W-1:0] + 1'b1;
    end
  end

  always_comb begin
    heap_we    = cmd.up_move || cmd.down_move || cmd.place;
    heap_waddr = s_r;
    slot_we    = heap_we;
    slot_wdata = s_r;
    if (cmd.up_move) begin
      heap_wdata = rd_a;
    end else if (cmd.down_move) begin
      heap_wdata = child;
    end else begin
      heap_wdata = '{id: id_r, pri: key_r};
    end
    slot_waddr = heap_wdata.id;
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    rd_a <= heap_mem[addr_a];
    rd_b <= heap_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    rd_slot <= slot_mem[id_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.check && chk == STAT_OK) begin
        if (kind_r == KIND_INSERT) begin
          count         <= count + 1'b1;
          present[id_r] <= 1'b1;
        end else if (kind_r == KIND_EXTRACT) begin
          count <= count - 1'b1;
        end
      end
      if (cmd.ext_take) present[rd_a.id] <= 1'b0;
      if (cmd.finish && sts.out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      id_r   <= in_id;
      key_r  <= $signed(in_pri);
    end
    if (cmd.check) begin
      stat <= chk;
      rid  <= '0;
      rpri <= '0;
      s_r  <= count[SLOT_W-1:0];
    end
    if (cmd.dec_slot) s_r <= rd_slot;
    if (cmd.dec_cmp && sts.not_lower) stat <= STAT_NOT_LOWER;
    if (cmd.up_move) s_r <= par;
    if (cmd.ext_take) begin
      rid   <= rd_a.id;
      rpri  <= rd_a.pri;
      id_r  <= rd_b.id;
      key_r <= rd_b.pri;
      s_r   <= '0;
      c_r   <= COUNT_W'(1);
    end
    if (cmd.down_move) begin
      s_r <= cidx;
      c_r <= {cidx, 1'b1};
    end
    if (cmd.finish && sts.out_free) begin
      out_id     <= rid;
      out_pri    <= rpri;
      out_status <= stat;
      out_count  <= count;
    end
  end

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY)) else $error("occupancy above capacity");
  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    cmd.up_move |-> s_r != '0) else $error("sift up past root");
  a_down_in_heap: assert property (@(posedge clk) disable iff (rst)
    cmd.down_move |-> c_r < count) else $error("sift down past last slot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif

endmodule
`default_nettype wire

FILE: rtl/indexed_min_heap_queue_unit.sv
`default_nettype none
// channel  direction  tdata (low bit up)                              tuser
// s_axis   in         entry_id[7:0], entry_priority[39:8]             kind[1:0]
// m_axis   out        removed_id[7:0], removed_priority[39:8],
//                     occupancy[48:40]                                status[2:0]
// one item at a time: a rejected item goes from the check straight to the
// finish, a decrease with a priority that is not lower ends after its compare;
// each heap level moved takes a test state, in which the registered read of
// the heap memory is made, and a compare state.
// reset empties the heap at once; no clearing pass.
// a result held on m_axis blocks only the finish of the next item.
module indexed_min_heap_queue_unit
  import ihq_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,  // entry_id, entry_priority
  input  wire  [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata,  // removed_id, removed_priority, occupancy, zero fill
  output logic [2:0]  m_axis_tuser   // status
);

  cmd_t               cmd;
  sts_t               sts;
  logic [ID_W-1:0]    out_id;
  logic [PRIO_W-1:0]  out_pri;
  status_t            out_status;
  logic [COUNT_W-1:0] out_count;

  ihq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ihq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (s_axis_tuser),
    .in_id      (s_axis_tdata[7:0]),
    .in_pri     (s_axis_tdata[39:8]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_id     (out_id),
    .out_pri    (out_pri),
    .out_status (out_status),
    .out_count  (out_count)
  );

  assign m_axis_tdata = {7'd0, out_count, out_pri, out_id};
  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire
